// ===== sv/evad_pkg.sv =====
// shared types and constants of the energy voice activity detector
`default_nettype none
package evad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SQUARE_W = 31;
  localparam int SUM_W    = 42;
  localparam int COUNT_W  = 12;
  localparam int THRESH_W = 16;
  localparam int RUN_W    = 8;
  localparam int LIMIT_W  = THRESH_W + COUNT_W;
  localparam int LIMIT_SHIFT = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = 3;
  localparam int OUTQ_CW    = 4;
  localparam int BUSY_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CHUNKS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHUNKS       = 2'd3;

  localparam logic [COUNT_W-1:0]  WINDOW_LENGTH_RST = 12'd1600;
  localparam logic [THRESH_W-1:0] THRESHOLD_RST     = 16'd52429;
  localparam logic [RUN_W-1:0]    START_CHUNKS_RST  = 8'd2;
  localparam logic [RUN_W-1:0]    END_CHUNKS_RST    = 8'd4;
  localparam logic [RUN_W-1:0]    RUN_MAX           = 8'd255;

  typedef struct packed {
    logic signed [31:0] raw_sample;
    logic               chunk_end;
  } evad_in_t;

  typedef struct packed {
    logic [SUM_W-1:0]   energy_sum;
    logic [COUNT_W-1:0] window_count;
    logic               loud_now;
    logic               speech_active;
    logic               speech_started;
    logic               speech_ended;
  } evad_out_t;

  typedef struct packed {
    logic               valid;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic [LIMIT_W-1:0] limit;
  } evad_meas_t;

endpackage
`default_nettype wire

// ===== sv/evad_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module evad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== sv/evad_energy.sv =====
// sample store, running sum of squares and threshold limit pipeline
`default_nettype none
module evad_energy #(
  parameter int WINDOW_DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_fire,
  input  wire evad_pkg::evad_in_t       in_beat,
  input  wire logic [evad_pkg::COUNT_W-1:0]  win,
  input  wire logic [evad_pkg::THRESH_W-1:0] threshold,
  input  wire logic                     clear,
  output      evad_pkg::evad_meas_t     meas,
  output      logic [evad_pkg::BUSY_W-1:0] busy
);
  import evad_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int PW = AW + 1;

  logic [AW-1:0]      wp_r;
  logic [AW-1:0]      wp_nxt;
  logic [COUNT_W-1:0] fill_r;
  logic [COUNT_W-1:0] fill_nxt;
  logic [SUM_W-1:0]   sum_r;
  logic [PW-1:0]      idx_sum;
  logic [AW-1:0]      old_idx;
  logic               old_used;
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [31:0] sq_new;
  logic signed [31:0] sq_old;
  logic [SAMPLE_W-1:0] rdata;

  logic               v1_r, v2_r, v3_r;
  logic               ce1_r, ce2_r, ce3_r;
  logic               old1_r;
  logic [SQUARE_W-1:0] sqn1_r, sqn2_r, sqo2_r;
  logic [COUNT_W-1:0] fill1_r, fill2_r, fill3_r;
  logic [LIMIT_W-1:0] lim2_r, lim3_r;

  // oldest sample slot, wrapped modulo the store depth
  always_comb begin
    idx_sum = {1'b0, wp_r} + PW'(WINDOW_DEPTH) - PW'(win);
    if (idx_sum >= PW'(WINDOW_DEPTH)) begin
      old_idx = AW'(idx_sum - PW'(WINDOW_DEPTH));
    end else begin
      old_idx = AW'(idx_sum);
    end
    old_used = (fill_r >= win);
    fill_nxt = old_used ? win : fill_r + 1'b1;
    wp_nxt   = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    smp      = in_beat.raw_sample[28:13];
    sq_new   = smp * smp;
    sq_old   = $signed(rdata) * $signed(rdata);
  end

  evad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (wp_r),
    .wdata (smp),
    .raddr (old_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (in_fire) begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
      end
      if (v2_r) begin
        sum_r <= sum_r - SUM_W'(sqo2_r) + SUM_W'(sqn2_r);
      end
      if (clear) begin
        fill_r <= '0;
        sum_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ce1_r   <= in_beat.chunk_end;
    old1_r  <= old_used;
    sqn1_r  <= sq_new[SQUARE_W-1:0];
    fill1_r <= fill_nxt;
    ce2_r   <= ce1_r;
    sqn2_r  <= sqn1_r;
    sqo2_r  <= old1_r ? sq_old[SQUARE_W-1:0] : '0;
    fill2_r <= fill1_r;
    lim2_r  <= threshold * fill1_r;
    ce3_r   <= ce2_r;
    fill3_r <= fill2_r;
    lim3_r  <= lim2_r;
  end

  assign meas.valid = v3_r & ce3_r;
  assign meas.sum   = sum_r;
  assign meas.count = fill3_r;
  assign meas.limit = lim3_r;
  assign busy = BUSY_W'(v1_r) + BUSY_W'(v2_r) + BUSY_W'(v3_r);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win) else $error("window fill beyond window length");
  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> $past(v2_r)) else $error("sum stage without older stage");
`endif

endmodule
`default_nettype wire

// ===== sv/evad_decide.sv =====
// chunk decision: threshold test, run counters and speech flag
`default_nettype none
module evad_decide (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire evad_pkg::evad_meas_t      meas,
  input  wire logic [evad_pkg::RUN_W-1:0] start_chunks,
  input  wire logic [evad_pkg::RUN_W-1:0] end_chunks,
  output      logic                      res_valid,
  output      evad_pkg::evad_out_t       res
);
  import evad_pkg::*;

  logic [RUN_W-1:0] loud_run_r, loud_run_nxt;
  logic [RUN_W-1:0] quiet_run_r, quiet_run_nxt;
  logic             speech_r, speech_nxt;
  logic             loud;
  logic             started;
  logic             ended;

  always_comb begin
    loud = meas.sum > {meas.limit, LIMIT_SHIFT'(0)};
    if (loud) begin
      loud_run_nxt  = (loud_run_r < RUN_MAX) ? loud_run_r + 1'b1 : loud_run_r;
      quiet_run_nxt = '0;
    end else begin
      quiet_run_nxt = (quiet_run_r < RUN_MAX) ? quiet_run_r + 1'b1 : quiet_run_r;
      loud_run_nxt  = '0;
    end
    started    = !speech_r && loud && (loud_run_nxt >= start_chunks);
    ended      = speech_r && !loud && (quiet_run_nxt >= end_chunks);
    speech_nxt = started ? 1'b1 : (ended ? 1'b0 : speech_r);

    res_valid          = meas.valid;
    res.energy_sum     = meas.sum;
    res.window_count   = meas.count;
    res.loud_now       = loud;
    res.speech_active  = speech_nxt;
    res.speech_started = started;
    res.speech_ended   = ended;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loud_run_r  <= '0;
      quiet_run_r <= '0;
      speech_r    <= 1'b0;
    end else if (meas.valid) begin
      loud_run_r  <= loud_run_nxt;
      quiet_run_r <= quiet_run_nxt;
      speech_r    <= speech_nxt;
    end
  end

`ifndef SYNTHESIS
  a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(loud_run_r != '0 && quiet_run_r != '0)) else $error("both run counters live");
  a_flag_follows: assert property (@(posedge clk) disable iff (!rst_n)
    meas.valid && started |=> speech_r) else $error("speech flag not set on start");
`endif

endmodule
`default_nettype wire

// ===== sv/evad_outq.sv =====
// result queue between the decision stage and the output channel
`default_nettype none
module evad_outq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire evad_pkg::evad_out_t          push_data,
  output      logic [evad_pkg::OUTQ_CW-1:0] count,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      evad_pkg::evad_out_t          out_data
);
  import evad_pkg::*;

  evad_out_t          q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_r;
  logic [OUTQ_AW-1:0] rd_r;
  logic [OUTQ_CW-1:0] cnt_r;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < OUTQ_CW'(OUTQ_DEPTH) || pop)) else $error("result queue overflow");
`endif

endmodule
`default_nettype wire

// ===== sv/energy_voice_activity_detector.sv =====
// top level of the energy voice activity detector
// Takes one sample beat per clock and, while the output accepts results, keeps
// up that rate for any mix of chunk ends. Each beat writes its 16-bit sample
// into a WINDOW_DEPTH-entry store and reads the sample leaving the window in
// the same cycle; the read sample and the squares are registered before the
// running sum is updated and the chunk decided, with a result only for beats
// marked as chunk end. Results wait in an eight-entry queue; input is held off
// only once the queue plus the three beats in flight could overflow it. The
// store needs no clearing after reset, as its read data is used only once the
// window has been filled since it was last emptied. Writing window_length
// empties the window; all registers should be written only while idle.
`default_nettype none
module energy_voice_activity_detector #(
  parameter int WINDOW_DEPTH = 2048
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire evad_pkg::evad_in_t                in_data,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      evad_pkg::evad_out_t               out_data,
  input  wire logic                              cfg_we,
  input  wire logic [evad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [evad_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import evad_pkg::*;

  logic [COUNT_W-1:0]  wlen_r;
  logic [THRESH_W-1:0] thr_r;
  logic [RUN_W-1:0]    start_r;
  logic [RUN_W-1:0]    end_r;
  logic [COUNT_W-1:0]  win_eff;
  logic                clear;
  logic                in_fire;
  evad_meas_t          meas;
  logic [BUSY_W-1:0]   busy;
  logic [OUTQ_CW-1:0]  q_count;
  logic                res_valid;
  evad_out_t           res;

  assign clear   = cfg_we && (cfg_index == CFG_WINDOW_LENGTH);
  assign in_fire = in_valid && in_ready;
  assign in_ready = (OUTQ_CW'(busy) + q_count) < OUTQ_CW'(OUTQ_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= WINDOW_LENGTH_RST;
      thr_r   <= THRESHOLD_RST;
      start_r <= START_CHUNKS_RST;
      end_r   <= END_CHUNKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:    wlen_r  <= cfg_wdata[COUNT_W-1:0];
        CFG_ENERGY_THRESHOLD: thr_r   <= cfg_wdata[THRESH_W-1:0];
        CFG_START_CHUNKS:     start_r <= cfg_wdata[RUN_W-1:0];
        CFG_END_CHUNKS:       end_r   <= cfg_wdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // window length clamped to one .. store depth
  always_comb begin
    if (wlen_r == '0) begin
      win_eff = COUNT_W'(1);
    end else if ({20'd0, wlen_r} > 32'(WINDOW_DEPTH)) begin
      win_eff = COUNT_W'(WINDOW_DEPTH);
    end else begin
      win_eff = wlen_r;
    end
  end

  evad_energy #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_energy (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_beat   (in_data),
    .win       (win_eff),
    .threshold (thr_r),
    .clear     (clear),
    .meas      (meas),
    .busy      (busy)
  );

  evad_decide u_decide (
    .clk          (clk),
    .rst_n        (rst_n),
    .meas         (meas),
    .start_chunks (start_r),
    .end_chunks   (end_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  evad_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .count     (q_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_event_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.speech_started && out_data.speech_ended))
    else $error("start and end in one beat");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for the energy voice activity detector: directed table, random chunks
`timescale 1ns / 1ps
module tb_top;
  import evad_pkg::*;

  localparam int HIST_DEPTH   = 2048;
  localparam int RANDOM_BEATS = 1300;
  localparam int SETTLE_WAIT  = 8;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    evad_in_t              beat;
    logic                  fixed_res;
    evad_out_t             want;
  } drill_row_t;

  localparam evad_out_t NO_RES = '0;
  localparam logic [SUM_W-1:0] FULL_SQ = 42'd1073741824;
  localparam logic [SUM_W-1:0] TOP_SQ  = 42'd1073676289;

  localparam drill_row_t DRILL [0:30] = '{
    '{ROW_BEAT, '0, '0, '{32'h0000_0000, 1'b1}, 1'b1, '{42'd0, 12'd1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{ROW_BEAT, '0, '0, '{32'h7FFF_FFFF, 1'b1}, 1'b1, '{42'd1, 12'd2, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{ROW_BEAT, '0, '0, '{32'h8000_0000, 1'b0}, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h1000_0000, 1'b1}, 1'b0, NO_RES},
    '{ROW_CFG, CFG_WINDOW_LENGTH, 16'd1, '0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_ENERGY_THRESHOLD, 16'd0, '0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_START_CHUNKS, 16'd0, '0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_END_CHUNKS, 16'd0, '0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h1000_0000, 1'b1}, 1'b1, '{FULL_SQ, 12'd1, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_BEAT, '0, '0, '{32'h0000_0000, 1'b1}, 1'b1, '{42'd0, 12'd1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{ROW_CFG, CFG_WINDOW_LENGTH, 16'd0, '0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h0FFF_E000, 1'b1}, 1'b1, '{TOP_SQ, 12'd1, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_CFG, CFG_ENERGY_THRESHOLD, 16'hFFFF, '0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h1000_0000, 1'b1}, 1'b1, '{FULL_SQ, 12'd1, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{ROW_BEAT, '0, '0, '{32'hEFFF_FFFF, 1'b1}, 1'b1, '{TOP_SQ, 12'd1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{ROW_CFG, CFG_WINDOW_LENGTH, 16'hFFFF, '0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_ENERGY_THRESHOLD, 16'd26214, '0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_START_CHUNKS, 16'hFF03, '0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_END_CHUNKS, 16'h0102, '0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h1000_0000, 1'b0}, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'hF000_0000, 1'b1}, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h0000_1FFF, 1'b1}, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h1000_0000, 1'b1}, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h0FFF_E000, 1'b1}, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'hFFFF_FFFF, 1'b1}, 1'b0, NO_RES},
    '{ROW_CFG, CFG_WINDOW_LENGTH, 16'd2048, '0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_START_CHUNKS, 16'd255, '0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_END_CHUNKS, 16'd255, '0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h8000_1FFF, 1'b1}, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'h5555_5555, 1'b0}, 1'b0, NO_RES},
    '{ROW_BEAT, '0, '0, '{32'hAAAA_AAAA, 1'b1}, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  evad_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  evad_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  energy_voice_activity_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [SAMPLE_W-1:0] hist [0:HIST_DEPTH-1];
  logic [10:0]         hist_ptr;
  logic [COUNT_W-1:0]  hist_fill;
  logic [SUM_W-1:0]    energy_acc;
  logic [RUN_W-1:0]    loud_streak;
  logic [RUN_W-1:0]    quiet_streak;
  logic                speaking;
  logic [COUNT_W-1:0]  win_reg;
  logic [THRESH_W-1:0] thresh_reg;
  logic [RUN_W-1:0]    start_reg;
  logic [RUN_W-1:0]    end_reg;

  evad_out_t chunk_results_due [$];
  int mismatch_count = 0;
  int beats_sent = 0;
  bit steady_feed = 1'b0;
  int unsigned cycle_count = 0;
  int stall_left = 0;
  int mode_left = 0;
  bit calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [SUM_W-1:0] square16(logic signed [SAMPLE_W-1:0] s);
    longint v;
    v = s;
    return SUM_W'(v * v);
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WINDOW_LENGTH: begin
        win_reg = val[COUNT_W-1:0];
        hist_fill = '0;
        energy_acc = '0;
      end
      CFG_ENERGY_THRESHOLD: thresh_reg = val[THRESH_W-1:0];
      CFG_START_CHUNKS: start_reg = val[RUN_W-1:0];
      CFG_END_CHUNKS: end_reg = val[RUN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit predict_chunk_result(evad_in_t beat, output evad_out_t res);
    logic [SAMPLE_W-1:0] smp;
    logic [COUNT_W-1:0]  eff_win;
    logic [10:0]         old_slot;
    logic [63:0]         limit;
    bit                  loud;
    res = '0;
    smp = beat.raw_sample[28:13];
    if (win_reg == '0) eff_win = 12'd1;
    else if (win_reg > 12'd2048) eff_win = 12'd2048;
    else eff_win = win_reg;
    if (hist_fill >= eff_win) begin
      old_slot = hist_ptr - eff_win[10:0];
      energy_acc = energy_acc - square16(hist[old_slot]) + square16(smp);
      hist_fill = eff_win;
    end else begin
      energy_acc = energy_acc + square16(smp);
      hist_fill = hist_fill + 1'b1;
    end
    hist[hist_ptr] = smp;
    hist_ptr = hist_ptr + 1'b1;
    if (!beat.chunk_end) return 1'b0;
    limit = (64'(thresh_reg) * 64'(hist_fill)) << LIMIT_SHIFT;
    loud = 64'(energy_acc) > limit;
    if (loud) begin
      if (loud_streak != RUN_MAX) loud_streak = loud_streak + 1'b1;
      quiet_streak = '0;
    end else begin
      if (quiet_streak != RUN_MAX) quiet_streak = quiet_streak + 1'b1;
      loud_streak = '0;
    end
    if (!speaking && loud && loud_streak >= start_reg) begin
      speaking = 1'b1;
      res.speech_started = 1'b1;
    end
    if (speaking && !loud && quiet_streak >= end_reg) begin
      speaking = 1'b0;
      res.speech_ended = 1'b1;
    end
    res.energy_sum = energy_acc;
    res.window_count = hist_fill;
    res.loud_now = loud;
    res.speech_active = speaking;
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(bit loud);
    logic [SAMPLE_W-1:0] smp;
    smp = loud ? 16'($urandom_range(20000, 32767)) : 16'($urandom_range(0, 3000));
    if ($urandom_range(0, 1) == 1) smp = -smp;
    if (loud && $urandom_range(0, 15) == 0) smp = 16'h8000;
    return smp;
  endfunction

  // bits outside the sample slot are random
  function automatic evad_in_t sample_beat(logic [SAMPLE_W-1:0] smp, bit ce);
    evad_in_t beat;
    beat.raw_sample = $urandom;
    beat.raw_sample[28:13] = smp;
    beat.chunk_end = ce;
    return beat;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(1, 48));
    if (r < 75) return 16'($urandom_range(49, 300));
    if (r < 85) return ($urandom_range(0, 1) == 1) ? 16'd2048 : 16'd1600;
    if (r < 92) return 16'd0;
    return 16'($urandom_range(2049, 65535));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 16'd0;
    if (r < 22) return 16'hFFFF;
    return 16'($urandom_range(2000, 60000));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_run_len();
    int r;
    logic [CFG_DATA_W-1:0] val;
    r = $urandom_range(0, 99);
    if (r < 8) val = 16'd0;
    else if (r < 16) val = 16'd255;
    else if (r < 80) val = 16'($urandom_range(1, 4));
    else val = 16'($urandom_range(5, 12));
    if ($urandom_range(0, 9) == 0) val[15:8] = 8'($urandom_range(1, 255));
    return val;
  endfunction

  task automatic send_beat(input evad_in_t beat, input bit use_fixed, input evad_out_t fixed);
    int gap;
    bit has_res;
    evad_out_t res;
    gap = (steady_feed || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_ready !== 1'b1);
    has_res = predict_chunk_result(beat, res);
    if (has_res) chunk_results_due.push_back(use_fixed ? fixed : res);
    beats_sent++;
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (chunk_results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_cfg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_saturation_phase();
    write_reg(CFG_WINDOW_LENGTH, 16'd1);
    write_reg(CFG_ENERGY_THRESHOLD, 16'd0);
    write_reg(CFG_START_CHUNKS, 16'd255);
    write_reg(CFG_END_CHUNKS, 16'd255);
    steady_feed = 1'b0;
    repeat (260) send_beat(sample_beat(pick_sample(1'b1), 1'b1), 1'b0, NO_RES);
    repeat (260) send_beat(sample_beat(16'h0000, 1'b1), 1'b0, NO_RES);
  endtask

  task automatic run_mixed_phase();
    int chunks;
    int len;
    int k;
    bit loud_mode;
    evad_in_t beat;
    if ($urandom_range(0, 3) != 0) write_reg(CFG_WINDOW_LENGTH, pick_window());
    if ($urandom_range(0, 3) != 0) write_reg(CFG_ENERGY_THRESHOLD, pick_threshold());
    if ($urandom_range(0, 2) != 0) write_reg(CFG_START_CHUNKS, pick_run_len());
    if ($urandom_range(0, 2) != 0) write_reg(CFG_END_CHUNKS, pick_run_len());
    steady_feed = ($urandom_range(0, 3) == 0);
    loud_mode = 1'($urandom_range(0, 1));
    chunks = $urandom_range(4, 16);
    repeat (chunks) begin
      if ($urandom_range(0, 24) == 0) settle_results();
      if ($urandom_range(0, 99) < 30) loud_mode = !loud_mode;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      for (k = 1; k <= len; k++) begin
        if ($urandom_range(0, 9) == 0) beat = sample_beat(16'($urandom), k == len);
        else beat = sample_beat(pick_sample(loud_mode), k == len);
        send_beat(beat, 1'b0, NO_RES);
      end
    end
  endtask

  // receiver stalls, with calm stretches in between
  always @(posedge clk) begin
    if (mode_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 25) stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin : result_check
    evad_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (chunk_results_due.size() == 0) begin
        $error("result beat with no chunk result pending");
        mismatch_count++;
      end else begin
        want = chunk_results_due.pop_front();
        if (out_data.energy_sum !== want.energy_sum) begin
          $error("energy_sum: expected %0d, got %0d", want.energy_sum, out_data.energy_sum);
          mismatch_count++;
        end
        if (out_data.window_count !== want.window_count) begin
          $error("window_count: expected %0d, got %0d", want.window_count,
                 out_data.window_count);
          mismatch_count++;
        end
        if (out_data.loud_now !== want.loud_now) begin
          $error("loud_now: expected %0d, got %0d", want.loud_now, out_data.loud_now);
          mismatch_count++;
        end
        if (out_data.speech_active !== want.speech_active) begin
          $error("speech_active: expected %0d, got %0d", want.speech_active,
                 out_data.speech_active);
          mismatch_count++;
        end
        if (out_data.speech_started !== want.speech_started) begin
          $error("speech_started: expected %0d, got %0d", want.speech_started,
                 out_data.speech_started);
          mismatch_count++;
        end
        if (out_data.speech_ended !== want.speech_ended) begin
          $error("speech_ended: expected %0d, got %0d", want.speech_ended,
                 out_data.speech_ended);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("energy_voice_activity_detector regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    int random_start;
    win_reg = WINDOW_LENGTH_RST;
    thresh_reg = THRESHOLD_RST;
    start_reg = START_CHUNKS_RST;
    end_reg = END_CHUNKS_RST;
    hist_ptr = '0;
    hist_fill = '0;
    energy_acc = '0;
    loud_streak = '0;
    quiet_streak = '0;
    speaking = 1'b0;
    foreach (hist[i]) hist[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DRILL[i]) begin
      if (DRILL[i].kind == ROW_CFG) begin
        settle_results();
        repeat (SETTLE_WAIT) @(posedge clk);
        write_reg(DRILL[i].idx, DRILL[i].wdata);
      end else begin
        send_beat(DRILL[i].beat, DRILL[i].fixed_res, DRILL[i].want);
      end
    end

    random_start = beats_sent;
    phase = 0;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      settle_results();
      repeat (SETTLE_WAIT) @(posedge clk);
      if (phase == 3) run_saturation_phase();
      else run_mixed_phase();
      phase++;
    end

    settle_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("energy_voice_activity_detector regression: pass");
    end else begin
      $display("energy_voice_activity_detector regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/evad_pkg.sv
sv/evad_ram.sv
sv/evad_energy.sv
sv/evad_decide.sv
sv/evad_outq.sv
sv/energy_voice_activity_detector.sv
sim/tb_top.sv
